// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the histogram block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/bhm_pkg.sv =====
package bhm_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int COUNT_WIDTH  = 16;
  localparam int SYM_W        = 8;
  localparam int OUT_COUNT_W  = 16;
  localparam int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 24;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SYM_W-1:0]       sym_t;
  typedef logic [IDX_W-1:0]       idx_t;

  // Clamp a counter value to the width of the result field.
  function automatic logic [OUT_COUNT_W-1:0] clamp_out(input count_t c);
    logic [32:0] wide;
    wide = 33'(c);
    if (wide > 33'((64'd1 << OUT_COUNT_W) - 64'd1)) begin
      return '1;
    end
    return wide[OUT_COUNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bhm_ram.sv =====
module bhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/byte_histogram_mode_unit.sv =====
// The last byte is registered into s1, then its result into the output register.
// One byte per cycle unless a last byte stalls; RAM read on accept, written in s1.
// A byte that follows the same value is served from a forwarding register, not the RAM.
// Counters clear at the end of each string through per-entry valid flops, with no sweep.
// Reset (rst, synchronous, active high) clears the valid flops, running best and both stages.
module byte_histogram_mode_unit
  import bhm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic                  s_axis_tlast,   // last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [7:0] mode_symbol, [23:8] mode_count
);

  logic                    s1_valid;
  sym_t                    s1_sym;
  logic                    s1_last;
  logic [SYMBOL_COUNT-1:0] cnt_valid;
  count_t                  best_count;
  sym_t                    best_symbol;
  logic                    fwd_valid;
  sym_t                    fwd_sym;
  count_t                  fwd_count;
  logic                    out_valid;
  sym_t                    out_symbol;
  logic [OUT_COUNT_W-1:0]  out_count;

  logic   adv;
  logic   accept;
  logic   proc;
  logic   counting;
  idx_t   s1_idx;
  count_t rd_data;
  count_t old_count;
  count_t new_count;
  logic   better;
  count_t best_count_next;
  sym_t   best_symbol_next;

  // The stage only stalls when a last byte waits for a full output register.
  assign adv           = !(s1_valid && s1_last && out_valid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign proc          = s1_valid && adv;

  assign s1_idx   = s1_sym[IDX_W-1:0];
  assign counting = (s1_sym != '0) &&
                    ({1'b0, s1_sym} < (SYM_W+1)'(SYMBOL_COUNT));

  bhm_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (SYMBOL_COUNT)
  ) u_counts (
    .clk   (clk),
    .we    (proc && counting),
    .waddr (s1_idx),
    .wdata (new_count),
    .re    (accept),
    .raddr (s_axis_tdata[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    if (!cnt_valid[s1_idx]) begin
      old_count = '0;
    end else if (fwd_valid && fwd_sym == s1_sym) begin
      old_count = fwd_count;
    end else begin
      old_count = rd_data;
    end
    new_count = (old_count == '1) ? old_count : old_count + COUNT_WIDTH'(1);
    better    = counting && ((new_count > best_count) ||
                             (new_count == best_count && s1_sym < best_symbol));
    best_count_next  = better ? new_count : best_count;
    best_symbol_next = better ? s1_sym : best_symbol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      cnt_valid   <= '0;
      best_count  <= '0;
      best_symbol <= '0;
      fwd_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= s_axis_tvalid;
      end
      if (proc) begin
        if (s1_last) begin
          cnt_valid   <= '0;
          best_count  <= '0;
          best_symbol <= '0;
          fwd_valid   <= 1'b0;
        end else begin
          best_count  <= best_count_next;
          best_symbol <= best_symbol_next;
          if (counting) begin
            cnt_valid[s1_idx] <= 1'b1;
            fwd_valid         <= 1'b1;
          end
        end
      end
      if (proc && s1_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sym  <= s_axis_tdata[SYM_W-1:0];
      s1_last <= s_axis_tlast;
    end
    if (proc && counting) begin
      fwd_sym   <= s1_sym;
      fwd_count <= new_count;
    end
    if (proc && s1_last) begin
      out_symbol <= best_symbol_next;
      out_count  <= clamp_out(best_count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_count, out_symbol};

endmodule

// ===== rtl/core/bhm_checker.sv =====
`include "assert_macros.svh"

module bhm_checker
  import bhm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata == '0);

  // Input is only held off while a result beat sits unaccepted.
  `ASSERT_SAME(a_ready_stall, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // A zero count can only come with symbol zero, and a nonzero count never with it.
  `ASSERT_SAME(a_empty_sym, clk, rst, m_axis_tvalid, (m_axis_tdata[23:8] == '0) == (m_axis_tdata[7:0] == '0))
  // A stalled result beat holds its data.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Nothing is offered in the cycle after reset.
  `ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid)
  // A zero byte with tlast still ends the string, so it still produces a result beat.
  `ASSERT_NEXT(a_empty_out, clk, rst, in_beat, ##1 m_axis_tvalid)

endmodule

bind byte_histogram_mode_unit bhm_checker u_bhm_checker (.*);

// ===== dv/byte_histogram_mode_unit_tb.sv =====
`timescale 1ns / 100ps

module byte_histogram_mode_unit_tb;
  import bhm_pkg::*;

  localparam int unsigned RUN_LIMIT     = 1_500_000;
  localparam int          RANDOM_ITEMS  = 700;
  localparam int          LONG_HOLD     = 300;

  typedef struct {
    logic [7:0] data;
    logic       last_flag;
  } string_byte_t;

  typedef struct {
    sym_t                   symbol;
    logic [OUT_COUNT_W-1:0] count;
  } mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] byte_value
  logic                  s_axis_tlast = 1'b0; // last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [7:0] mode_symbol, [23:8] mode_count

  byte_histogram_mode_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow of the histogram and the running leader.
  count_t symbol_tally [SYMBOL_COUNT];
  count_t lead_count;
  sym_t   lead_symbol;

  string_byte_t pending_bytes [$];
  mode_t        expected_modes [$];

  int          error_count     = 0;
  int          bytes_queued    = 0;
  int          bytes_taken     = 0;
  int          strings_taken   = 0;
  int          modes_checked   = 0;
  int          input_stalls    = 0;
  int unsigned cycle_count     = 0;
  logic        in_taken        = 1'b0;
  logic        quiet_tail      = 1'b0;
  int          send_gap        = 0;
  int          recv_gap        = 0;
  int          hold_requests   = 0;
  int          hold_served     = 0;
  int          long_hold_left  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_tally();
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      symbol_tally[i] = '0;
    end
    lead_count  = '0;
    lead_symbol = '0;
  endfunction

  // Counts one accepted byte; on the last byte of a string the mode is queued.
  function automatic void tally_byte(logic [7:0] data, logic last_flag);
    count_t      c;
    logic [32:0] wide;
    mode_t       m;
    if (data != 8'd0 && int'(data) < SYMBOL_COUNT) begin
      c = symbol_tally[data];
      if (c != '1) begin
        c = c + 1'b1;
      end
      symbol_tally[data] = c;
      if (c > lead_count || (c == lead_count && sym_t'(data) < lead_symbol)) begin
        lead_count  = c;
        lead_symbol = sym_t'(data);
      end
    end
    if (last_flag) begin
      wide     = 33'(lead_count);
      m.symbol = lead_symbol;
      m.count  = (wide > 33'({OUT_COUNT_W{1'b1}})) ? '1 : wide[OUT_COUNT_W-1:0];
      expected_modes.push_back(m);
      clear_tally();
    end
  endfunction

  function automatic void check_mode(logic [OUT_DATA_W-1:0] beat);
    mode_t m;
    if (expected_modes.size() == 0) begin
      $display("%0t: unexpected result beat, symbol %0d count %0d", $time,
               beat[7:0], beat[23:8]);
      error_count++;
      return;
    end
    m = expected_modes.pop_front();
    modes_checked++;
    if (beat[7:0] !== m.symbol) begin
      $display("%0t: mode_symbol expected %0d got %0d", $time, m.symbol, beat[7:0]);
      error_count++;
    end
    if (beat[23:8] !== m.count) begin
      $display("%0t: mode_count expected %0d got %0d", $time, m.count, beat[23:8]);
      error_count++;
    end
  endfunction

  // Monitor: handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && !s_axis_tready) begin
        input_stalls++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        if (s_axis_tlast) begin
          strings_taken++;
        end
        tally_byte(s_axis_tdata[7:0], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_mode(m_axis_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               expected_modes.size());
      $display("byte_histogram_mode_unit_tb failed");
      $finish;
    end
  end

  // Byte driver: a beat is held until it is taken, with random gaps between beats.
  always @(negedge clk) begin
    string_byte_t b;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= send_gap - 1;
    end else if (pending_bytes.size() != 0) begin
      b = pending_bytes.pop_front();
      s_axis_tdata  <= b.data;
      s_axis_tlast  <= b.last_flag;
      s_axis_tvalid <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(1, 4);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result sink: short random stalls, plus one long hold on request.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served    <= hold_requests;
      long_hold_left <= LONG_HOLD;
      m_axis_tready  <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
      m_axis_tready  <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap      <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        recv_gap <= $urandom_range(1, 4);
      end
    end
  end

  task automatic queue_byte(logic [7:0] data, logic last_flag);
    string_byte_t b;
    b.data      = data;
    b.last_flag = last_flag;
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // A string drawn mostly from a tiny alphabet so repeats and ties are common.
  task automatic queue_random_string(int max_len);
    int         len;
    int         alpha_n;
    logic [7:0] alphabet [4];
    logic [7:0] b;
    len     = ($urandom_range(0, 19) == 0) ? $urandom_range(max_len, 4 * max_len)
                                           : $urandom_range(1, max_len);
    alpha_n = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) begin
      alphabet[i] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 11))
        0:       b = 8'd0;
        1:       b = 8'($urandom_range(0, 255));
        default: b = alphabet[$urandom_range(0, alpha_n - 1)];
      endcase
      queue_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid) begin
      @(posedge clk);
    end
    while (expected_modes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int target;
    clear_tally();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings: empty, extremes, zero bytes, ties and repeats.
    queue_byte(8'd0, 1'b1);
    queue_byte(8'd255, 1'b1);
    queue_byte(8'd1, 1'b1);
    queue_byte(8'd5, 1'b0);
    queue_byte(8'd0, 1'b0);
    queue_byte(8'd5, 1'b1);
    queue_byte(8'd7, 1'b0);
    queue_byte(8'd0, 1'b1);
    queue_byte(8'd9, 1'b0);
    queue_byte(8'd3, 1'b0);
    queue_byte(8'd3, 1'b0);
    queue_byte(8'd9, 1'b1);
    queue_byte(8'd200, 1'b0);
    queue_byte(8'd100, 1'b1);
    queue_byte(8'd42, 1'b0);
    queue_byte(8'd42, 1'b0);
    queue_byte(8'd42, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h80, 1'b1);
    wait_for_drain();

    target = bytes_queued + RANDOM_ITEMS * 2 / 5;
    while (bytes_queued < target) begin
      queue_random_string(10);
    end
    // The sender pauses here until every pending result is back.
    wait_for_drain();

    // Results back up behind a long sink hold while short strings keep coming.
    hold_requests = hold_requests + 1;
    for (int i = 0; i < 60; i++) begin
      queue_random_string(2);
    end
    target = bytes_queued + RANDOM_ITEMS * 2 / 5;
    while (bytes_queued < target) begin
      queue_random_string(10);
    end
    wait_for_drain();

    quiet_tail = 1'b1;
    target = bytes_queued + RANDOM_ITEMS / 5;
    while (bytes_queued < target) begin
      queue_random_string(8);
    end
    wait_for_drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d strings and checked %0d modes.", bytes_taken,
             strings_taken, modes_checked);
    $display("Input was held off for %0d cycles; %0d mismatches seen.", input_stalls,
             error_count);
    if (error_count == 0) begin
      $display("byte_histogram_mode_unit_tb passed");
    end else begin
      $display("byte_histogram_mode_unit_tb failed");
    end
    $finish;
  end

endmodule
